// ===== rtl/ffea_pkg.sv =====
`timescale 1ns / 1ps

package ffea_pkg;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_A_RD,
        S_A_CMP,
        S_F_RD,
        S_F_CMP,
        S_F_DEC,
        S_SL_RD,
        S_SL_WR,
        S_SR_RD,
        S_SR_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_P1,
        RD_K_M1
    } t_rd_sel;

    typedef enum logic [3:0] {
        WR_NONE,
        WR_INIT,
        WR_SHRINK,
        WR_LEFT_MERGE,
        WR_BOTH_MERGE,
        WR_RIGHT_MERGE,
        WR_SHL,
        WR_SHR,
        WR_INSERT
    } t_wr_op;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  size;
    } t_extent;

    typedef struct packed {
        logic    capture;
        t_rd_sel rd;
        t_wr_op  wr;
        logic    idx_inc;
        logic    save_prev;
        logic    set_right;
        logic    clr_right;
        logic    k_load;
        logic    k_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        t_status status_val;
        logic    set_got;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic len_zero;
        logic out_of_heap;
        logic count_zero;
        logic last;
        logic exact;
        logic bigger;
        logic addr_le;
        logic right_overlap;
        logic left_overlap;
        logic join_l;
        logic join_r;
        logic full;
        logic sr_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/ffea_ctrl.sv =====
`timescale 1ns / 1ps

module ffea_ctrl import ffea_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr = WR_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.kind == KIND_ALLOC) begin
                    if (i_sts.count_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status_val = ST_OOM;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_A_RD;
                    end
                end else begin
                    priority if (i_sts.len_zero) begin
                        n_state = S_DONE;
                    end else if (i_sts.out_of_heap) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status_val = ST_INVALID;
                        n_state          = S_DONE;
                    end else if (i_sts.count_zero) begin
                        n_state = S_F_DEC;
                    end else begin
                        n_state = S_F_RD;
                    end
                end
            end
            S_A_RD: begin
                o_cmd.rd = RD_IDX;
                n_state  = S_A_CMP;
            end
            S_A_CMP: begin
                priority if (i_sts.exact) begin
                    o_cmd.set_got = 1'b1;
                    n_state       = S_SL_RD;
                end else if (i_sts.bigger) begin
                    o_cmd.set_got = 1'b1;
                    o_cmd.wr      = WR_SHRINK;
                    n_state       = S_DONE;
                end else if (i_sts.last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_OOM;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_A_RD;
                end
            end
            S_F_RD: begin
                o_cmd.rd = RD_IDX;
                n_state  = S_F_CMP;
            end
            S_F_CMP: begin
                priority if (i_sts.addr_le) begin
                    o_cmd.set_right = 1'b1;
                    n_state         = S_F_DEC;
                end else if (i_sts.last) begin
                    o_cmd.save_prev = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    o_cmd.clr_right = 1'b1;
                    n_state         = S_F_DEC;
                end else begin
                    o_cmd.save_prev = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = S_F_RD;
                end
            end
            S_F_DEC: begin
                priority if (i_sts.right_overlap || i_sts.left_overlap) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_INVALID;
                    n_state          = S_DONE;
                end else if (i_sts.join_l && i_sts.join_r) begin
                    o_cmd.wr = WR_BOTH_MERGE;
                    n_state  = S_SL_RD;
                end else if (i_sts.join_l) begin
                    o_cmd.wr = WR_LEFT_MERGE;
                    n_state  = S_DONE;
                end else if (i_sts.join_r) begin
                    o_cmd.wr = WR_RIGHT_MERGE;
                    n_state  = S_DONE;
                end else if (i_sts.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.k_load = 1'b1;
                    n_state      = S_SR_RD;
                end
            end
            S_SL_RD: begin
                if (i_sts.last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd = RD_IDX_P1;
                    n_state  = S_SL_WR;
                end
            end
            S_SL_WR: begin
                o_cmd.wr      = WR_SHL;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_SL_RD;
            end
            S_SR_RD: begin
                if (i_sts.sr_done) begin
                    o_cmd.wr      = WR_INSERT;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd = RD_K_M1;
                    n_state  = S_SR_WR;
                end
            end
            S_SR_WR: begin
                o_cmd.wr    = WR_SHR;
                o_cmd.k_dec = 1'b1;
                n_state     = S_SR_RD;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/ffea_dpath.sv =====
`timescale 1ns / 1ps

module ffea_dpath import ffea_pkg::*; #(
    parameter int HEAP_BYTES  = 65536,
    parameter int MAX_EXTENTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [LEN_W-1:0]  i_len,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output t_status           o_status,
    output logic [ADDR_W-1:0] o_alloc_addr
);

    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [LEN_W-1:0] HEAP_LEN = LEN_W'(HEAP_BYTES);
    localparam logic [CW-1:0]    MAX_CNT  = CW'(MAX_EXTENTS);

    t_extent r_mem [MAX_EXTENTS];

    logic              r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [CW-1:0]     r_idx;
    logic [IW-1:0]     r_k;
    logic [CW-1:0]     r_count;
    t_extent           r_rd;
    t_extent           r_prev;
    logic              r_has_right;
    t_status           r_status;
    logic [ADDR_W-1:0] r_got;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [ADDR_W-1:0] r_out_addr;

    logic [LEN_W-1:0]  w_end;
    logic [LEN_W-1:0]  w_left_end;
    logic [LEN_W-1:0]  w_rd_start;
    logic [CW-1:0]     w_idx_p1;
    logic [CW-1:0]     w_idx_m1;
    logic              w_has_left;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    t_extent           w_wdata;

    assign w_end      = {1'b0, r_addr} + r_len;
    assign w_left_end = {1'b0, r_prev.start} + r_prev.size;
    assign w_rd_start = {1'b0, r_rd.start};
    assign w_idx_p1   = r_idx + 1'b1;
    assign w_idx_m1   = r_idx - 1'b1;
    assign w_has_left = (r_idx != '0);

    always_comb begin
        w_re    = 1'b1;
        w_raddr = '0;
        unique case (i_cmd.rd)
            RD_NONE:   w_re    = 1'b0;
            RD_IDX:    w_raddr = r_idx[IW-1:0];
            RD_IDX_P1: w_raddr = w_idx_p1[IW-1:0];
            RD_K_M1:   w_raddr = r_k - 1'b1;
            default:   w_re    = 1'b0;
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_idx[IW-1:0];
        w_wdata = r_rd;
        unique case (i_cmd.wr)
            WR_NONE: begin
                w_we = 1'b0;
            end
            WR_INIT: begin
                w_waddr = '0;
                w_wdata = '{start: '0, size: HEAP_LEN};
            end
            WR_SHRINK: begin
                w_wdata = '{start: r_rd.start + r_len[ADDR_W-1:0], size: r_rd.size - r_len};
            end
            WR_LEFT_MERGE: begin
                w_waddr = w_idx_m1[IW-1:0];
                w_wdata = '{start: r_prev.start, size: r_prev.size + r_len};
            end
            WR_BOTH_MERGE: begin
                w_waddr = w_idx_m1[IW-1:0];
                w_wdata = '{start: r_prev.start, size: r_prev.size + r_len + r_rd.size};
            end
            WR_RIGHT_MERGE: begin
                w_wdata = '{start: r_addr, size: r_rd.size + r_len};
            end
            WR_SHL: begin
                w_wdata = r_rd;
            end
            WR_SHR: begin
                w_waddr = r_k;
            end
            WR_INSERT: begin
                w_wdata = '{start: r_addr, size: r_len};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_addr <= i_addr;
            r_len  <= i_len;
        end
        if (i_cmd.save_prev) begin
            r_prev <= r_rd;
        end
        if (i_cmd.k_load) begin
            r_k <= r_count[IW-1:0];
        end else if (i_cmd.k_dec) begin
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.capture) begin
            r_status <= ST_OK;
            r_got    <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_val;
            end
            if (i_cmd.set_got) begin
                r_got <= r_rd.start;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_got;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= CW'(1);
            r_has_right <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_p1;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.capture || i_cmd.clr_right) begin
                r_has_right <= 1'b0;
            end else if (i_cmd.set_right) begin
                r_has_right <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.kind          = r_kind;
        o_sts.len_zero      = (r_len == '0);
        o_sts.out_of_heap   = (w_end > HEAP_LEN);
        o_sts.count_zero    = (r_count == '0);
        o_sts.last          = (w_idx_p1 >= r_count);
        o_sts.exact         = (r_rd.size == r_len);
        o_sts.bigger        = (r_rd.size > r_len);
        o_sts.addr_le       = (r_addr <= r_rd.start);
        o_sts.right_overlap = r_has_right && (w_end > w_rd_start);
        o_sts.left_overlap  = w_has_left && (w_left_end > {1'b0, r_addr});
        o_sts.join_l        = w_has_left && (w_left_end == {1'b0, r_addr});
        o_sts.join_r        = r_has_right && (w_end == w_rd_start);
        o_sts.full          = (r_count >= MAX_CNT);
        o_sts.sr_done       = (CW'(r_k) <= r_idx);
        o_sts.out_busy      = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_status     = r_out_status;
    assign o_alloc_addr = r_out_addr;

endmodule

// ===== rtl/first_fit_extent_allocator_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                   tuser
// s_axis    in         block_addr[15:0], block_len[32:16]   kind
// m_axis    out        alloc_addr[15:0]                     status[1:0]
//
// one request at a time: accept, dispatch, a read and a compare per entry scanned, a decision on free,
// a read and a write per entry moved on remove or insert plus a finishing step, then the result load
// reset: after release the init state writes table entry zero, then requests are taken
// a new request is accepted while the previous result waits in the output register;
// completion stalls only if that register is still full

module first_fit_extent_allocator_unit import ffea_pkg::*; #(
    parameter int HEAP_BYTES  = 65536,
    parameter int MAX_EXTENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // block_addr[15:0], block_len[32:16], zero pad
    input  logic        i_s_tuser,  // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // alloc_addr[15:0]
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_status w_status;

    ffea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ffea_dpath #(
        .HEAP_BYTES  (HEAP_BYTES),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_s_tuser),
        .i_addr       (i_s_tdata[ADDR_W-1:0]),
        .i_len        (i_s_tdata[ADDR_W+LEN_W-1:ADDR_W]),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_status     (w_status),
        .o_alloc_addr (o_m_tdata)
    );

    assign o_m_tuser = w_status;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ffea_pkg::*;

    localparam int HEAP_BYTES  = 65536;
    localparam int MAX_EXTENTS = 16;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        t_status     status;
        logic [15:0] alloc_addr;
    } reply_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // block_addr[15:0], block_len[32:16], zero pad
    logic        i_s_tuser;   // kind
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // alloc_addr[15:0]
    logic [1:0]  o_m_tuser;   // status[1:0]

    // free extent table as the block should hold it
    logic [15:0] free_start [MAX_EXTENTS];
    logic [16:0] free_size  [MAX_EXTENTS];
    int          free_count;

    reply_t      expected_replies[$];
    int          held_addr[$];
    int          held_len[$];
    int          last_free_addr = 0;
    int          last_free_len = 0;
    bit          no_idle = 1'b0;
    bit          any_error = 1'b0;
    int          cycle_count = 0;

    first_fit_extent_allocator_unit #(
        .HEAP_BYTES (HEAP_BYTES),
        .MAX_EXTENTS(MAX_EXTENTS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** first_fit_extent_allocator_unit: FAILED **");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic void remove_extent(input int idx);
        int k;
        for (k = idx; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k + 1];
            free_size[k]  = free_size[k + 1];
        end
        free_count--;
    endfunction

    function automatic t_status predict_alloc(input int len, output logic [15:0] addr);
        int i;
        addr = '0;
        for (i = 0; i < free_count; i++) begin
            if (int'(free_size[i]) == len) begin
                addr = free_start[i];
                remove_extent(i);
                return ST_OK;
            end
            if (int'(free_size[i]) > len) begin
                addr = free_start[i];
                free_start[i] = 16'(int'(free_start[i]) + len);
                free_size[i]  = 17'(int'(free_size[i]) - len);
                return ST_OK;
            end
        end
        return ST_OOM;
    endfunction

    function automatic t_status predict_free(input int addr, input int len);
        int  i;
        int  k;
        int  stop;
        int  left_end;
        bit  has_left;
        bit  has_right;
        bit  join_l;
        bit  join_r;
        if (len == 0) begin
            return ST_OK;
        end
        stop = addr + len;
        if (stop > HEAP_BYTES) begin
            return ST_INVALID;
        end
        for (i = 0; i < free_count; i++) begin
            if (addr <= int'(free_start[i])) begin
                break;
            end
        end
        has_left  = (i > 0);
        has_right = (i < free_count);
        left_end  = has_left ? int'(free_start[i - 1]) + int'(free_size[i - 1]) : 0;
        if (has_right && stop > int'(free_start[i])) begin
            return ST_INVALID;
        end
        if (has_left && left_end > addr) begin
            return ST_INVALID;
        end
        join_l = has_left && (left_end == addr);
        join_r = has_right && (stop == int'(free_start[i]));
        if (join_l && join_r) begin
            free_size[i - 1] = 17'(int'(free_size[i - 1]) + len + int'(free_size[i]));
            remove_extent(i);
        end else if (join_l) begin
            free_size[i - 1] = 17'(int'(free_size[i - 1]) + len);
        end else if (join_r) begin
            free_start[i] = 16'(addr);
            free_size[i]  = 17'(int'(free_size[i]) + len);
        end else begin
            if (free_count >= MAX_EXTENTS) begin
                return ST_FULL;
            end
            for (k = free_count; k > i; k--) begin
                free_start[k] = free_start[k - 1];
                free_size[k]  = free_size[k - 1];
            end
            free_start[i] = 16'(addr);
            free_size[i]  = 17'(len);
            free_count++;
        end
        return ST_OK;
    endfunction

    // valid stays high after acceptance; the next request or a gap decides
    task automatic send_request(input logic kind, input int addr, input int len,
                                output t_status status, output logic [15:0] got);
        int     gap;
        reply_t want;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {7'd0, len[16:0], addr[15:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        got = '0;
        if (kind == KIND_ALLOC) begin
            status = predict_alloc(len, got);
        end else begin
            status = predict_free(addr, len);
        end
        want.status     = status;
        want.alloc_addr = got;
        expected_replies.push_back(want);
    endtask

    task automatic request(input logic kind, input int addr, input int len);
        t_status     st;
        logic [15:0] got;
        send_request(kind, addr, len, st, got);
    endtask

    task automatic allocate(input int len);
        t_status     st;
        logic [15:0] got;
        send_request(KIND_ALLOC, $urandom_range(0, 65535), len, st, got);
        if (st == ST_OK && len > 0) begin
            held_addr.push_back(int'(got));
            held_len.push_back(len);
        end
    endtask

    // piece: 0 whole block, 1 low piece, 2 high piece
    task automatic release_held(input int idx, input int piece);
        int          a;
        int          n;
        int          cut;
        t_status     st;
        logic [15:0] got;
        a = held_addr[idx];
        n = held_len[idx];
        if (piece == 0 || n < 2) begin
            send_request(KIND_FREE, a, n, st, got);
            last_free_addr = a;
            last_free_len  = n;
            if (st == ST_OK || st == ST_INVALID) begin
                held_addr.delete(idx);
                held_len.delete(idx);
            end
        end else begin
            cut = $urandom_range(1, n - 1);
            if (piece == 1) begin
                send_request(KIND_FREE, a, cut, st, got);
                last_free_addr = a;
            end else begin
                send_request(KIND_FREE, a + n - cut, cut, st, got);
                last_free_addr = a + n - cut;
            end
            last_free_len = cut;
            if (st == ST_OK) begin
                if (piece == 1) begin
                    held_addr[idx] = a + cut;
                end
                held_len[idx] = n - cut;
            end
        end
    endtask

    // uncomplicated walk through every merge case and the OOM and INVALID errors from reset
    task automatic test_directed_cases();
        request(KIND_ALLOC, 'hFFFF, 0);
        request(KIND_FREE,  'h1234, 0);
        request(KIND_ALLOC, 'h0000, 65536);
        request(KIND_ALLOC, 'h5555, 0);
        request(KIND_ALLOC, 'hAAAA, 1);
        request(KIND_FREE,  'hFFFF, 2);
        request(KIND_FREE,  'h0100, 'h100);
        request(KIND_FREE,  'h0180, 'h10);
        request(KIND_FREE,  'h00F0, 'h20);
        request(KIND_FREE,  'h0300, 'h100);
        request(KIND_FREE,  'h0200, 'h100);
        request(KIND_FREE,  'h0080, 'h80);
        request(KIND_FREE,  'h0400, 'h10);
        request(KIND_FREE,  'h0000, 'h10);
        request(KIND_FREE,  'hFFFF, 1);
        request(KIND_FREE,  'h8000, 'h8000);
        request(KIND_ALLOC, 'h0000, 65536);
        request(KIND_ALLOC, 'h0000, 'h10);
        request(KIND_ALLOC, 'h0000, 'h20);
        request(KIND_ALLOC, 'h0000, 0);
        request(KIND_FREE,  'h0000, 'h10);
        request(KIND_FREE,  'h0080, 'h20);
        request(KIND_FREE,  'h0410, 'hFBEF);
        request(KIND_FREE,  'h0010, 'h70);
    endtask

    // alternate holes until the extent table overflows
    task automatic test_table_full();
        int base;
        int i;
        base = held_addr.size();
        repeat (40) allocate(64);
        for (i = held_addr.size() - 1; i >= base; i -= 2) begin
            release_held(i, 0);
        end
    endtask

    task automatic test_random_traffic();
        int n;
        int pick;
        int len;
        int sel;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 150 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (held_addr.size() == 0 || (pick < 45 && held_addr.size() < 48)) begin
                sel = $urandom_range(0, 19);
                if (sel < 12) begin
                    len = $urandom_range(1, 256);
                end else if (sel < 17) begin
                    len = $urandom_range(257, 4096);
                end else if (sel < 19) begin
                    len = $urandom_range(4097, 65536);
                end else begin
                    len = $urandom_range(0, 1) ? 65536 : 0;
                end
                allocate(len);
            end else if (pick < 88) begin
                sel = $urandom_range(0, 3);
                release_held($urandom_range(0, held_addr.size() - 1),
                             sel == 0 ? $urandom_range(1, 2) : 0);
            end else if (pick < 93) begin
                request(KIND_FREE, last_free_addr, last_free_len);
            end else begin
                len = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 65536);
                request(KIND_FREE, $urandom_range(0, 65535), len);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_return_everything();
        int tries;
        for (tries = 0; held_addr.size() > 0 && tries < 200; tries++) begin
            release_held($urandom_range(0, held_addr.size() - 1), 0);
        end
        request(KIND_ALLOC, 'h0000, 65536);
        request(KIND_FREE,  'h0000, 65536);
    endtask

    initial begin : result_sink
        int stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(o_m_tvalid && i_m_tready)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        reply_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result: status %0d alloc_addr 0x%04h",
                       o_m_tuser, o_m_tdata);
                any_error = 1'b1;
            end else begin
                want = expected_replies.pop_front();
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                    any_error = 1'b1;
                end
                if (o_m_tdata !== want.alloc_addr) begin
                    $error("alloc_addr: expected 0x%04h, got 0x%04h",
                           want.alloc_addr, o_m_tdata);
                    any_error = 1'b1;
                end
            end
        end
    end

    initial begin
        int i;
        for (i = 0; i < MAX_EXTENTS; i++) begin
            free_start[i] = '0;
            free_size[i]  = '0;
        end
        free_size[0] = 17'(HEAP_BYTES);
        free_count   = 1;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_ALLOC;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_random_traffic();
        test_return_everything();

        i_s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_EXTENTS + 8) @(posedge i_clk);
        if (!any_error) begin
            $display("** first_fit_extent_allocator_unit: PASSED **");
        end else begin
            $display("** first_fit_extent_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule
